FILE: hdl/sbif_pkg.sv
package sbif_pkg;

    // Packet framing bytes and instruction codes
    localparam logic [7:0] FRAME_START  = 8'hFF;
    localparam logic [7:0] ID_BROADCAST = 8'hFE;
    localparam logic [7:0] OP_READ      = 8'h02;
    localparam logic [7:0] OP_WRITE     = 8'h03;
    localparam logic [7:0] OP_REG_WRITE = 8'h04;
    localparam logic [7:0] OP_ACTION    = 8'h05;

    // Command modes
    localparam logic [1:0] MODE_READ      = 2'd0;
    localparam logic [1:0] MODE_WRITE     = 2'd1;
    localparam logic [1:0] MODE_REG_WRITE = 2'd2;
    localparam logic [1:0] MODE_ACTION    = 2'd3;

    // Length byte values
    localparam logic [7:0] LEN_ACTION = 8'd2;
    localparam logic [7:0] LEN_NARROW = 8'd4;
    localparam logic [7:0] LEN_WIDE   = 8'd5;

    // Parameter counts
    localparam logic [1:0] NPAR_NONE   = 2'd0;
    localparam logic [1:0] NPAR_NARROW = 2'd2;
    localparam logic [1:0] NPAR_WIDE   = 2'd3;

    // Byte positions inside a packet
    localparam logic [3:0] POS_START0 = 4'd0;
    localparam logic [3:0] POS_START1 = 4'd1;
    localparam logic [3:0] POS_ID     = 4'd2;
    localparam logic [3:0] POS_LEN    = 4'd3;
    localparam logic [3:0] POS_OP     = 4'd4;
    localparam logic [3:0] POS_PARAM0 = 4'd5;
    localparam logic [3:0] POS_PARAM1 = 4'd6;
    localparam logic [3:0] POS_PARAM2 = 4'd7;

    // Configuration port
    localparam int             PADDR_W         = 3;
    localparam logic [7:0]     DEVICE_ID_RESET = 8'd1;
    localparam logic [PADDR_W-3:0] REG_DEVICE_ID = '0;

    // Command queue
    localparam int QUEUE_DEPTH = 2;

    // Classified command, everything the back end needs to serialize a packet
    typedef struct packed {
        logic [7:0]      id;
        logic [7:0]      len;
        logic [7:0]      op;
        logic [2:0][7:0] param;
        logic [1:0]      npar;
        logic [7:0]      chk;
    } sbif_cmd_t;

endpackage

FILE: hdl/sbif_front.sv
module sbif_front
    import sbif_pkg::*;
(
    input  logic [7:0]  device_id,
    input  logic [1:0]  mode,
    input  logic        wide,
    input  logic [7:0]  address,
    input  logic [15:0] value,
    output sbif_cmd_t   cmd
);

    logic [7:0] sum;

    // Classify the command into header, parameters and count
    always_comb
    begin
        cmd = '0;
        case (mode)
            MODE_READ:
            begin
                cmd.id       = device_id;
                cmd.op       = OP_READ;
                cmd.len      = LEN_NARROW;
                cmd.npar     = NPAR_NARROW;
                cmd.param[0] = address;
                cmd.param[1] = wide ? 8'd2 : 8'd1;
            end
            MODE_WRITE, MODE_REG_WRITE:
            begin
                cmd.id       = device_id;
                cmd.op       = (mode == MODE_WRITE) ? OP_WRITE : OP_REG_WRITE;
                cmd.len      = wide ? LEN_WIDE : LEN_NARROW;
                cmd.npar     = wide ? NPAR_WIDE : NPAR_NARROW;
                cmd.param[0] = address;
                cmd.param[1] = value[7:0];
                cmd.param[2] = wide ? value[15:8] : 8'd0;
            end
            default:
            begin
                cmd.id   = ID_BROADCAST;
                cmd.op   = OP_ACTION;
                cmd.len  = LEN_ACTION;
                cmd.npar = NPAR_NONE;
            end
        endcase
        // Unused parameter slots are zero, so the sum covers all slots
        sum     = cmd.id + cmd.len + cmd.op + cmd.param[0] + cmd.param[1] + cmd.param[2];
        cmd.chk = ~sum;
    end

endmodule

FILE: hdl/sbif_queue.sv
module sbif_queue
    import sbif_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  sbif_cmd_t push_cmd,
    input  logic      pop,
    output sbif_cmd_t head_cmd,
    output logic      empty,
    output logic      full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sbif_cmd_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign head_cmd = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/sbif_back.sv
module sbif_back
    import sbif_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sbif_cmd_t  head_cmd,
    input  logic       head_valid,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] tx_byte,
    output logic       last
);

    logic [3:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       last_reg;
    logic       load;
    logic       final_byte;

    assign load       = head_valid && (!out_valid_reg || !out_stall);
    assign final_byte = (pos_reg == POS_PARAM0 + {2'b00, head_cmd.npar});
    assign pop        = load && final_byte;

    // Select the byte at the current position
    always_comb
    begin
        if (final_byte)
        begin
            tx_byte_next = head_cmd.chk;
        end
        else
        begin
            case (pos_reg)
                POS_START0: tx_byte_next = FRAME_START;
                POS_START1: tx_byte_next = FRAME_START;
                POS_ID:     tx_byte_next = head_cmd.id;
                POS_LEN:    tx_byte_next = head_cmd.len;
                POS_OP:     tx_byte_next = head_cmd.op;
                POS_PARAM0: tx_byte_next = head_cmd.param[0];
                POS_PARAM1: tx_byte_next = head_cmd.param[1];
                POS_PARAM2: tx_byte_next = head_cmd.param[2];
                default:    tx_byte_next = head_cmd.chk;
            endcase
        end
    end

    // Advance position and hold the output while stalled
    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            pos_next       = final_byte ? POS_START0 : pos_reg + 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_START0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tx_byte_reg <= tx_byte_next;
            last_reg    <= final_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign last      = last_reg;

endmodule

FILE: hdl/servo_bus_instruction_framer.sv
// The command item is written into the queue, and the first byte of its packet is then loaded into the output register.
// Throughput: one byte per cycle from the output register while out_stall is low; a packet is 6 bytes
// (action), 8 (read, narrow write) or 9 (wide write); packets follow with no gap.
// The command queue lets new items in while the current packet is still going out.
// Reset: device_id returns to 1, the queue empties and no byte is valid.
module servo_bus_instruction_framer
    import sbif_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Command channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic               wide,
    input  logic [7:0]         address,
    input  logic [15:0]        value,
    // Byte channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         tx_byte,
    output logic               last
);

    logic [7:0] device_id_reg;
    logic       reg_sel;
    logic       push;
    logic       pop;
    logic       empty;
    logic       full;
    sbif_cmd_t  front_cmd;
    sbif_cmd_t  head_cmd;

    // Decode and write the configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_DEVICE_ID);
    assign prdata  = reg_sel ? {24'd0, device_id_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= DEVICE_ID_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            device_id_reg <= pwdata[7:0];
        end
    end

    // Accept items while the queue has room
    assign in_stall = full;
    assign push     = in_valid && !full;

    sbif_front u_front (
        .device_id (device_id_reg),
        .mode      (mode),
        .wide      (wide),
        .address   (address),
        .value     (value),
        .cmd       (front_cmd)
    );

    sbif_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty),
        .full     (full)
    );

    sbif_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (!empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_byte    (tx_byte),
        .last       (last)
    );

    // A packet that ends is followed only by a start byte
    a_start_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid || tx_byte == FRAME_START)
        else $error("packet does not open with a start byte");

    // Bytes of one packet go out without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside a packet");

    // The queue never pops while empty
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty command queue");

endmodule

FILE: verif/tb_servo_bus_instruction_framer.sv
module tb_servo_bus_instruction_framer;
    import sbif_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] ADDR_DEVICE_ID = '0;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 50;

    // One byte of an instruction packet as the block should send it
    typedef struct packed {
        logic [7:0] data;
        logic       eop;
    } pkt_byte_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         mode = MODE_READ;
    logic               wide = 1'b0;
    logic [7:0]         address = '0;
    logic [15:0]        value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         tx_byte;
    logic               last;

    // Predictor state and the bytes still owed by the block
    logic [7:0] servo_id = DEVICE_ID_RESET;
    pkt_byte_t  pending_bytes[$];
    int         errors = 0;
    int         burst_left = 0;
    int         rx_cycle = 0;
    int         quiet_cycles = 0;

    servo_bus_instruction_framer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .wide      (wide),
        .address   (address),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tx_byte   (tx_byte),
        .last      (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Build the packet for one command and queue its bytes
    function automatic void frame_packet(input logic [1:0] m, input logic w,
                                         input logic [7:0] a, input logic [15:0] v);
        logic [7:0] body[$];
        logic [7:0] sum;
        sum = '0;
        if (m == MODE_ACTION)
            body = '{ID_BROADCAST, LEN_ACTION, OP_ACTION};
        else if (m == MODE_READ)
            body = '{servo_id, LEN_NARROW, OP_READ, a, w ? 8'd2 : 8'd1};
        else if (w)
            body = '{servo_id, LEN_WIDE, (m == MODE_WRITE) ? OP_WRITE : OP_REG_WRITE,
                     a, v[7:0], v[15:8]};
        else
            body = '{servo_id, LEN_NARROW, (m == MODE_WRITE) ? OP_WRITE : OP_REG_WRITE,
                     a, v[7:0]};
        pending_bytes.push_back('{FRAME_START, 1'b0});
        pending_bytes.push_back('{FRAME_START, 1'b0});
        foreach (body[i])
        begin
            pending_bytes.push_back('{body[i], 1'b0});
            sum = sum + body[i];
        end
        pending_bytes.push_back('{~sum, 1'b1});
    endfunction

    // Offer one command item, hold it until taken, then maybe open a gap
    task automatic send_cmd(input logic [1:0] m, input logic w,
                            input logic [7:0] a, input logic [15:0] v);
        in_valid <= 1'b1;
        mode     <= m;
        wide     <= w;
        address  <= a;
        value    <= v;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        frame_packet(m, w, a, v);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
        else
            burst_left--;
    endtask

    // Stop sending and wait for every owed byte to come out
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_device_id(input logic [7:0] id);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DEVICE_ID;
        pwdata  <= {24'd0, id};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        servo_id = id;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_device_id();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DEVICE_ID;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {24'd0, servo_id})
        begin
            errors++;
            $display("%0t: device_id read expected %h actual %h", $time,
                     {24'd0, servo_id}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Every mode and field extreme with the reset ID
    task automatic test_default_id();
        check_device_id();
        send_cmd(MODE_READ, 1'b0, 8'h00, 16'h0000);
        send_cmd(MODE_READ, 1'b1, 8'hFF, 16'hFFFF);
        send_cmd(MODE_WRITE, 1'b0, 8'hFF, 16'hA5FF);
        send_cmd(MODE_WRITE, 1'b1, 8'h00, 16'hFFFF);
        send_cmd(MODE_REG_WRITE, 1'b0, 8'h1E, 16'hFF00);
        send_cmd(MODE_REG_WRITE, 1'b1, 8'hFF, 16'h0000);
        send_cmd(MODE_ACTION, 1'b1, 8'hFF, 16'hFFFF);
        send_cmd(MODE_ACTION, 1'b0, 8'h00, 16'h0000);
        drain();
    endtask

    // ID extremes, including the out-of-range 254 and 255 passed through as is
    task automatic test_id_extremes();
        logic [7:0] ids[4];
        ids = '{8'd0, 8'd253, 8'd254, 8'd255};
        foreach (ids[i])
        begin
            write_device_id(ids[i]);
            check_device_id();
            send_cmd(MODE_READ, 1'b1, 8'h24, 16'h1234);
            send_cmd(MODE_WRITE, 1'b1, 8'hFF, 16'hFFFF);
            send_cmd(MODE_ACTION, 1'b0, 8'h55, 16'hAAAA);
            drain();
        end
    endtask

    // Random commands over several ID settings
    task automatic test_random_traffic();
        logic [7:0]  a;
        logic [15:0] v;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                1: write_device_id(8'd0);
                3: write_device_id(8'd255);
                default: write_device_id(8'($urandom_range(0, 253)));
            endcase
            check_device_id();
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                a = 8'($urandom);
                v = 16'($urandom);
                if ($urandom_range(0, 7) == 0)
                    a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                if ($urandom_range(0, 7) == 0)
                    v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                send_cmd(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), a, v);
            end
            drain();
        end
    endtask

    // Compare each accepted byte, then pick the next stall on a phased pattern
    always @(posedge clk)
    begin
        pkt_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: tx_byte expected none actual %h (last %b)", $time,
                         tx_byte, last);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (tx_byte !== want.data)
                begin
                    errors++;
                    $display("%0t: tx_byte expected %h actual %h", $time, want.data, tx_byte);
                end
                if (last !== want.eop)
                begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time, want.eop, last);
                end
            end
        end
        rx_cycle++;
        case ((rx_cycle / 150) % 4)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ((rx_cycle % 7) < 3);
        endcase
    end

    // Count cycles where work is owed but nothing moves
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (!in_valid && pending_bytes.size() == 0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[servo_bus_instruction_framer] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_id();
        test_id_extremes();
        test_random_traffic();
        repeat (16) @(posedge clk);
        if (errors == 0 && pending_bytes.size() == 0)
            $display("[servo_bus_instruction_framer] OK");
        else
            $display("[servo_bus_instruction_framer] ERROR");
        $finish;
    end

endmodule
